// ----- hw/rtl/infix_to_postfix_converter_defines.svh -----
// assertion macros for the infix to postfix converter
`ifndef INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ITP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define ITP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/itp_pkg.sv -----
// shared types, constants and operator tables of the infix to postfix converter
package itp_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W       = $clog2(STACK_DEPTH);

	typedef logic [2:0] op_t;

	localparam op_t OP_OPEN  = 3'd0;
	localparam op_t OP_PLUS  = 3'd1;
	localparam op_t OP_MINUS = 3'd2;
	localparam op_t OP_MUL   = 3'd3;
	localparam op_t OP_DIV   = 3'd4;
	localparam op_t OP_POW   = 3'd5;
	localparam op_t OP_NONE  = 3'd7;

	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_MUL   = 8'h2a;
	localparam logic [7:0] CH_DIV   = 8'h2f;
	localparam logic [7:0] CH_POW   = 8'h5e;

	// micro-operations of one step, applied when the step's jump is not taken and the step is not held
	typedef struct packed {
		logic load;
		logic emit_top;
		logic emit_sym;
		logic emit_err;
		logic pop;
		logic push;
		logic finish;
	} act_t;

	localparam act_t ACT_NONE     = '0;
	localparam act_t ACT_LOAD     = '{load: 1'b1, default: 1'b0};
	localparam act_t ACT_EMIT_TOP = '{emit_top: 1'b1, default: 1'b0};
	localparam act_t ACT_EMIT_SYM = '{emit_sym: 1'b1, default: 1'b0};
	localparam act_t ACT_EMIT_ERR = '{emit_err: 1'b1, default: 1'b0};
	localparam act_t ACT_POP      = '{pop: 1'b1, default: 1'b0};
	localparam act_t ACT_PUSH     = '{push: 1'b1, default: 1'b0};
	localparam act_t ACT_FINISH   = '{finish: 1'b1, default: 1'b0};

	// datapath flags tested by the sequencer
	typedef struct packed {
		logic end_f;
		logic close_f;
		logic opnd_f;
		logic open_f;
		logic nopop_f;
		logic full_f;
		logic empty_f;
		logic stopcl_f;
		logic out_blocked;
	} status_t;

	function automatic op_t code_of(logic [7:0] c);
		op_t r;
		unique case (c)
			CH_OPEN:  r = OP_OPEN;
			CH_PLUS:  r = OP_PLUS;
			CH_MINUS: r = OP_MINUS;
			CH_MUL:   r = OP_MUL;
			CH_DIV:   r = OP_DIV;
			CH_POW:   r = OP_POW;
			default:  r = OP_NONE;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] prio_of(op_t op);
		logic [1:0] r;
		unique case (op) inside
			OP_PLUS, OP_MINUS: r = 2'd1;
			OP_MUL, OP_DIV:    r = 2'd2;
			OP_POW:            r = 2'd3;
			default:           r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] char_of(op_t op);
		logic [7:0] r;
		unique case (op)
			OP_OPEN:  r = CH_OPEN;
			OP_PLUS:  r = CH_PLUS;
			OP_MINUS: r = CH_MINUS;
			OP_MUL:   r = CH_MUL;
			OP_DIV:   r = CH_DIV;
			OP_POW:   r = CH_POW;
			default:  r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// ----- hw/rtl/itp_seq.sv -----
// microcode table and step counter of the converter
module itp_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  itp_pkg::status_t  status,
	output logic              load_step,
	output itp_pkg::act_t     act
);

	typedef logic [3:0] upc_t;

	localparam logic [3:0] C_NEVER  = 4'd0;
	localparam logic [3:0] C_NOIN   = 4'd1;
	localparam logic [3:0] C_END    = 4'd2;
	localparam logic [3:0] C_CLOSE  = 4'd3;
	localparam logic [3:0] C_OPND   = 4'd4;
	localparam logic [3:0] C_OPEN   = 4'd5;
	localparam logic [3:0] C_NOPOP  = 4'd6;
	localparam logic [3:0] C_FULL   = 4'd7;
	localparam logic [3:0] C_EMPTY  = 4'd8;
	localparam logic [3:0] C_STOPCL = 4'd9;

	localparam upc_t S_IDLE    = 4'd0;
	localparam upc_t S_ISEND   = 4'd1;
	localparam upc_t S_ISCLOSE = 4'd2;
	localparam upc_t S_ISOPND  = 4'd3;
	localparam upc_t S_ISOPEN  = 4'd4;
	localparam upc_t S_OPLOOP  = 4'd5;
	localparam upc_t S_PUSHCHK = 4'd6;
	localparam upc_t S_ERR     = 4'd7;
	localparam upc_t S_FLUSH   = 4'd8;
	localparam upc_t S_CLOSE   = 4'd9;
	localparam upc_t S_CLCHK   = 4'd10;
	localparam upc_t S_OPND    = 4'd11;
	localparam upc_t S_FIN     = 4'd12;

	typedef struct packed {
		logic [3:0]     cond;
		upc_t           target;
		upc_t           nxt;
		itp_pkg::act_t  act;
	} uword_t;

	function automatic uword_t uw(logic [3:0] c, upc_t t, upc_t n, itp_pkg::act_t a);
		uword_t w;
		w.cond   = c;
		w.target = t;
		w.nxt    = n;
		w.act    = a;
		return w;
	endfunction

	upc_t   upc_q;
	uword_t word;
	logic   cond_hit;
	logic   needs_out;
	logic   hold;

	// control store
	always_comb begin
		unique case (upc_q)
			S_IDLE:    word = uw(C_NOIN,   S_IDLE,    S_ISEND,   itp_pkg::ACT_LOAD);
			S_ISEND:   word = uw(C_END,    S_FLUSH,   S_ISCLOSE, itp_pkg::ACT_NONE);
			S_ISCLOSE: word = uw(C_CLOSE,  S_CLOSE,   S_ISOPND,  itp_pkg::ACT_NONE);
			S_ISOPND:  word = uw(C_OPND,   S_OPND,    S_ISOPEN,  itp_pkg::ACT_NONE);
			S_ISOPEN:  word = uw(C_OPEN,   S_PUSHCHK, S_OPLOOP,  itp_pkg::ACT_NONE);
			S_OPLOOP:  word = uw(C_NOPOP,  S_PUSHCHK, S_OPLOOP,
				itp_pkg::act_t'(itp_pkg::ACT_EMIT_TOP | itp_pkg::ACT_POP));
			S_PUSHCHK: word = uw(C_FULL,   S_ERR,     S_FIN,     itp_pkg::ACT_PUSH);
			S_ERR:     word = uw(C_NEVER,  S_IDLE,    S_FIN,     itp_pkg::ACT_EMIT_ERR);
			S_FLUSH:   word = uw(C_EMPTY,  S_FIN,     S_FLUSH,
				itp_pkg::act_t'(itp_pkg::ACT_EMIT_TOP | itp_pkg::ACT_POP));
			S_CLOSE:   word = uw(C_STOPCL, S_CLCHK,   S_CLOSE,
				itp_pkg::act_t'(itp_pkg::ACT_EMIT_TOP | itp_pkg::ACT_POP));
			S_CLCHK:   word = uw(C_EMPTY,  S_ERR,     S_FIN,     itp_pkg::ACT_POP);
			S_OPND:    word = uw(C_NEVER,  S_IDLE,    S_FIN,     itp_pkg::ACT_EMIT_SYM);
			S_FIN:     word = uw(C_NEVER,  S_IDLE,    S_IDLE,    itp_pkg::ACT_FINISH);
			default:   word = uw(C_NEVER,  S_IDLE,    S_IDLE,    itp_pkg::ACT_NONE);
		endcase
	end

	// condition select
	always_comb begin
		unique case (word.cond)
			C_NOIN:   cond_hit = !in_valid;
			C_END:    cond_hit = status.end_f;
			C_CLOSE:  cond_hit = status.close_f;
			C_OPND:   cond_hit = status.opnd_f;
			C_OPEN:   cond_hit = status.open_f;
			C_NOPOP:  cond_hit = status.nopop_f;
			C_FULL:   cond_hit = status.full_f;
			C_EMPTY:  cond_hit = status.empty_f;
			C_STOPCL: cond_hit = status.stopcl_f;
			default:  cond_hit = 1'b0;
		endcase
	end

	assign needs_out = word.act.emit_top | word.act.emit_sym | word.act.emit_err
		| word.act.finish;
	assign hold      = !cond_hit && needs_out && status.out_blocked;
	assign load_step = word.act.load;
	assign act       = (cond_hit || hold) ? itp_pkg::ACT_NONE : word.act;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= S_IDLE;
		end else if (cond_hit) begin
			upc_q <= word.target;
		end else if (!hold) begin
			upc_q <= word.nxt;
		end
	end

endmodule

// ----- hw/rtl/itp_dp.sv -----
// operator stack, input latch, pending result and output register
module itp_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  itp_pkg::act_t     act,
	input  logic [7:0]        symbol,
	input  logic              end_of_expression,
	input  logic              out_stall,
	output itp_pkg::status_t  status,
	output logic              out_valid,
	output logic [7:0]        out_symbol,
	output logic              last_of_run,
	output logic              error_flag
);

	itp_pkg::op_t                  stack_q [itp_pkg::STACK_DEPTH];
	logic [itp_pkg::CNT_W-1:0]     cnt_q;
	logic [7:0]                    sym_q;
	logic                          end_q;
	logic                          pend_v_q;
	logic [7:0]                    pend_sym_q;
	logic                          pend_err_q;
	logic                          out_v_q;
	logic [7:0]                    out_sym_q;
	logic                          out_last_q;
	logic                          out_err_q;

	itp_pkg::op_t                  in_code;
	itp_pkg::op_t                  top;
	logic [itp_pkg::IDX_W-1:0]     top_idx;
	logic                          empty;
	logic                          emit;
	logic [7:0]                    emit_sym;
	logic                          move_out;

	assign in_code = itp_pkg::code_of(sym_q);
	assign top_idx = itp_pkg::IDX_W'(cnt_q - itp_pkg::CNT_W'(1));
	assign top     = stack_q[top_idx];
	assign empty   = (cnt_q == '0);

	assign status.end_f       = end_q;
	assign status.close_f     = (sym_q == itp_pkg::CH_CLOSE);
	assign status.opnd_f      = (in_code == itp_pkg::OP_NONE);
	assign status.open_f      = (in_code == itp_pkg::OP_OPEN);
	assign status.nopop_f     = empty || (itp_pkg::prio_of(top) < itp_pkg::prio_of(in_code));
	assign status.full_f      = (cnt_q == itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH));
	assign status.empty_f     = empty;
	assign status.stopcl_f    = empty || (top == itp_pkg::OP_OPEN);
	assign status.out_blocked = pend_v_q && out_v_q && out_stall;

	assign emit     = act.emit_top | act.emit_sym | act.emit_err;
	assign emit_sym = act.emit_top ? itp_pkg::char_of(top) :
		(act.emit_sym ? sym_q : 8'h00);
	assign move_out = pend_v_q && (emit || act.finish);

	always_ff @(posedge clk) begin
		if (act.load) begin
			sym_q <= symbol;
			end_q <= end_of_expression;
		end
		if (act.push) begin
			stack_q[cnt_q[itp_pkg::IDX_W-1:0]] <= in_code;
		end
		if (emit) begin
			pend_sym_q <= emit_sym;
			pend_err_q <= act.emit_err;
		end
		if (move_out) begin
			out_sym_q  <= pend_sym_q;
			out_err_q  <= pend_err_q;
			out_last_q <= act.finish;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (act.push) begin
				cnt_q <= cnt_q + itp_pkg::CNT_W'(1);
			end else if (act.pop) begin
				cnt_q <= cnt_q - itp_pkg::CNT_W'(1);
			end
			if (emit) begin
				pend_v_q <= 1'b1;
			end else if (act.finish) begin
				pend_v_q <= 1'b0;
			end
			if (move_out) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_v_q;
	assign out_symbol  = out_sym_q;
	assign last_of_run = out_last_q;
	assign error_flag  = out_err_q;

endmodule

// ----- hw/rtl/infix_to_postfix_converter.sv -----
// top level of the shunting-yard infix to postfix converter
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_stall  | symbol[7:0], end_of_expression
//  out     | out_valid/ out_stall | out_symbol[7:0], last_of_run, error_flag
//
// an item is taken only in the idle step, then dispatch steps, a pop loop that emits and pops,
// a push or error step and a step to close the run; every pop loop ends with a check step
// every result waits in a pending register until the next emit or finish, so last_of_run is known on the move out
// out_stall only freezes steps that need to move a result
// reset empties the stack and both result registers at once with no clearing pass
`include "infix_to_postfix_converter_defines.svh"

module infix_to_postfix_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  symbol,
	input  logic        end_of_expression,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_symbol,
	output logic        last_of_run,
	output logic        error_flag
);

	itp_pkg::status_t status;
	itp_pkg::act_t    act;
	logic             load_step;

	// sequencer: control store, condition select and step counter
	itp_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.status    (status),
		.load_step (load_step),
		.act       (act)
	);

	// datapath: stack, latched item, pending and output result
	itp_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.act               (act),
		.symbol            (symbol),
		.end_of_expression (end_of_expression),
		.out_stall         (out_stall),
		.status            (status),
		.out_valid         (out_valid),
		.out_symbol        (out_symbol),
		.last_of_run       (last_of_run),
		.error_flag        (error_flag)
	);

	// the input side is open only in the idle step
	assign in_stall = !load_step;

	// once an item is taken the sequencer leaves the idle step
	`ITP_ASSERT_NEXT(a_leave_idle, clk, arst_n, in_valid && !in_stall, in_stall, "idle held after item")

	// an error result always closes its run and carries a zero character
	`ITP_ASSERT_IMPL(a_err_last, clk, arst_n, out_valid && error_flag, last_of_run && (out_symbol == 8'h00), "bad error result")

	// a push is never issued onto a full stack
	`ITP_ASSERT_IMPL(a_no_ovf_push, clk, arst_n, act.push, !status.full_f, "push onto full stack")

endmodule

// ----- verif/tb.sv -----
// self-checking testbench of the shunting-yard infix to postfix converter
module tb;

	import itp_pkg::*;

	// one emitted postfix character as seen on the result channel
	typedef struct {
		logic [7:0] sym;
		logic       last;
		logic       err;
	} postfix_char_t;

	// predicts the postfix stream and checks the emitted characters in order
	class postfix_scoreboard;
		postfix_char_t expected_q[$];
		op_t           op_stack[STACK_DEPTH];
		int unsigned   stack_used;
		int unsigned   mismatches;

		function new();
			stack_used = 0;
			mismatches = 0;
		endfunction

		function op_t op_code_for(logic [7:0] c);
			case (c)
				CH_OPEN:  return OP_OPEN;
				CH_PLUS:  return OP_PLUS;
				CH_MINUS: return OP_MINUS;
				CH_MUL:   return OP_MUL;
				CH_DIV:   return OP_DIV;
				CH_POW:   return OP_POW;
				default:  return OP_NONE;
			endcase
		endfunction

		// binding strength, open paren weakest
		function int rank_of(op_t op);
			case (op)
				OP_PLUS, OP_MINUS: return 1;
				OP_MUL, OP_DIV:    return 2;
				OP_POW:            return 3;
				default:           return 0;
			endcase
		endfunction

		function logic [7:0] glyph_of(op_t op);
			case (op)
				OP_OPEN:  return CH_OPEN;
				OP_PLUS:  return CH_PLUS;
				OP_MINUS: return CH_MINUS;
				OP_MUL:   return CH_MUL;
				OP_DIV:   return CH_DIV;
				OP_POW:   return CH_POW;
				default:  return 8'h00;
			endcase
		endfunction

		function postfix_char_t make_char(logic [7:0] sym, logic err);
			postfix_char_t c;
			c.sym  = sym;
			c.last = 1'b0;
			c.err  = err;
			return c;
		endfunction

		function postfix_char_t pop_top();
			stack_used--;
			return make_char(glyph_of(op_stack[stack_used]), 1'b0);
		endfunction

		// accepted input item: work out every character it causes
		function void note_symbol(logic [7:0] sym, logic eoe);
			postfix_char_t run[$];
			op_t           code;
			bit            matched;
			if (eoe) begin
				while (stack_used > 0)
					run.push_back(pop_top());
			end else if (sym == CH_CLOSE) begin
				matched = 0;
				while (stack_used > 0 && !matched) begin
					if (op_stack[stack_used - 1] == OP_OPEN) begin
						stack_used--;
						matched = 1;
					end else begin
						run.push_back(pop_top());
					end
				end
				if (!matched)
					run.push_back(make_char(8'h00, 1'b1));
			end else begin
				code = op_code_for(sym);
				if (code == OP_NONE) begin
					run.push_back(make_char(sym, 1'b0));
				end else begin
					if (code != OP_OPEN) begin
						while (stack_used > 0 && rank_of(op_stack[stack_used - 1]) >= rank_of(code))
							run.push_back(pop_top());
					end
					if (stack_used >= STACK_DEPTH) begin
						run.push_back(make_char(8'h00, 1'b1));
					end else begin
						op_stack[stack_used] = code;
						stack_used++;
					end
				end
			end
			if (run.size() > 0)
				run[run.size() - 1].last = 1'b1;
			foreach (run[i])
				expected_q.push_back(run[i]);
		endfunction

		function void check_output(logic [7:0] sym, logic last, logic err);
			postfix_char_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output: sym=%h last=%b err=%b", sym, last, err);
			end else begin
				want = expected_q.pop_front();
				if (sym !== want.sym || last !== want.last || err !== want.err) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected sym=%h last=%b err=%b, got sym=%h last=%b err=%b",
							want.sym, want.last, want.err, sym, last, err);
				end
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		// leftover expectations count as failures
		function int unsigned close_out();
			if (expected_q.size() > 0) begin
				$display("%0d expected outputs never arrived", expected_q.size());
				mismatches += expected_q.size();
			end
			return mismatches;
		endfunction
	endclass

	localparam int unsigned LIMIT_CYCLES = 400000;
	// worst single item: dispatch plus a full stack of pops, with margin
	localparam int unsigned SETTLE_CYCLES = 64;
	localparam int unsigned PHASE_ITEMS = 45;

	localparam logic [7:0] BINARY_OPS[5] = '{CH_PLUS, CH_MINUS, CH_MUL, CH_DIV, CH_POW};
	// every operator with both priorities equal and rising, ^ twice for its associativity
	localparam logic [7:0] MIXED_EXPR[13] = '{"a", CH_PLUS, "b", CH_MUL, "c", CH_POW, "d",
		CH_POW, "e", CH_MINUS, "f", CH_DIV, "g"};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] symbol = 8'h00;
	logic       end_of_expression = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_symbol;
	logic       last_of_run;
	logic       error_flag;

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned items_sent = 0;
	int unsigned cycle_count = 0;
	int unsigned fail_total;

	postfix_scoreboard sb = new();

	infix_to_postfix_converter u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.symbol            (symbol),
		.end_of_expression (end_of_expression),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.out_symbol        (out_symbol),
		.last_of_run       (last_of_run),
		.error_flag        (error_flag)
	);

	always #10 clk = ~clk;

	// runaway guard, far above the slowest legal run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("tb failed");
			$finish;
		end
	end

	// result side: check what was taken at this edge, then pick the next stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_output(out_symbol, last_of_run, error_flag);
		out_stall <= (recv_idle_pct > 0) && ($urandom_range(0, 99) < recv_idle_pct);
	end

	function automatic bit is_operator_char(logic [7:0] c);
		return c == CH_OPEN || c == CH_CLOSE || c == CH_PLUS || c == CH_MINUS ||
			c == CH_MUL || c == CH_DIV || c == CH_POW;
	endfunction

	// half plain letters, half any byte that is not an operator
	function automatic logic [7:0] pick_operand();
		logic [7:0] v;
		if ($urandom_range(0, 1) == 0)
			return 8'("a" + $urandom_range(0, 25));
		do
			v = 8'($urandom_range(0, 255));
		while (is_operator_char(v));
		return v;
	endfunction

	function automatic logic [7:0] pick_operator();
		return BINARY_OPS[$urandom_range(0, 4)];
	endfunction

	// offer one item, idling first at the current rate, and hold it until taken
	task automatic drive_item(input logic [7:0] sym, input logic eoe);
		while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid          <= 1'b1;
		symbol            <= sym;
		end_of_expression <= eoe;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_symbol(sym, eoe);
		items_sent++;
	endtask

	// sender holds off until every expected character is out, then lets the block settle
	task automatic drain_outputs();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// well-formed expression with random operands, operators and nesting
	task automatic send_expression();
		int unsigned tokens;
		int unsigned opens;
		bit          want_operand;
		tokens       = $urandom_range(1, 10);
		opens        = 0;
		want_operand = 1;
		for (int unsigned k = 0; k < tokens; k++) begin
			if (want_operand) begin
				if ($urandom_range(0, 99) < 25) begin
					drive_item(CH_OPEN, 1'b0);
					opens++;
				end else begin
					drive_item(pick_operand(), 1'b0);
					want_operand = 0;
				end
			end else if (opens > 0 && $urandom_range(0, 99) < 35) begin
				drive_item(CH_CLOSE, 1'b0);
				opens--;
			end else begin
				drive_item(pick_operator(), 1'b0);
				want_operand = 1;
			end
		end
		if (want_operand)
			drive_item(pick_operand(), 1'b0);
		// sometimes leave open parens for the flush to emit
		while (opens > 0 && $urandom_range(0, 3) != 0) begin
			drive_item(CH_CLOSE, 1'b0);
			opens--;
		end
		drive_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// broken input: stray bytes, operators in odd places, unmatched close parens
	task automatic send_noise();
		int unsigned n;
		n = $urandom_range(1, 8);
		repeat (n) begin
			if ($urandom_range(0, 1) == 0)
				drive_item(8'($urandom_range(0, 255)), 1'b0);
			else if ($urandom_range(0, 3) == 0)
				drive_item(CH_CLOSE, 1'b0);
			else if ($urandom_range(0, 2) == 0)
				drive_item(CH_OPEN, 1'b0);
			else
				drive_item(pick_operator(), 1'b0);
		end
		if ($urandom_range(0, 1) == 0)
			drive_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// nesting near and past the stack depth, sometimes a run of closes, then a flush
	task automatic send_deep_nest();
		int unsigned n;
		n = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 2);
		repeat (n) drive_item(CH_OPEN, 1'b0);
		drive_item(pick_operator(), 1'b0);
		drive_item(pick_operand(), 1'b0);
		if ($urandom_range(0, 1) == 0)
			repeat ($urandom_range(1, 4)) drive_item(CH_CLOSE, 1'b0);
		drive_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// mostly well-formed expressions, some noise, the odd overflow
	task automatic run_random(input int unsigned count);
		int unsigned goal;
		int unsigned pick;
		goal = items_sent + count;
		while (items_sent < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 80)
				send_expression();
			else if (pick < 95)
				send_noise();
			else
				send_deep_nest();
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender sparse idling, receiver heavy stalling
		send_idle_pct = 21;
		recv_idle_pct = 65;

		// operand extremes and a space pass straight through
		drive_item(8'h00, 1'b0);
		drive_item(8'hff, 1'b0);
		drive_item(" ", 1'b0);
		// flush of an empty stack gives nothing, symbol ignored
		drive_item(8'hff, 1'b1);
		// all operators, equal priority pops, left-associative power
		foreach (MIXED_EXPR[i])
			drive_item(MIXED_EXPR[i], 1'b0);
		drive_item(8'h00, 1'b1);
		// unmatched close paren on an empty stack: error only
		drive_item(CH_CLOSE, 1'b0);
		// matched close paren with nothing above it: no output
		drive_item(CH_OPEN, 1'b0);
		drive_item(CH_CLOSE, 1'b0);
		// unmatched close paren drains the stack, then the error
		drive_item(CH_MUL, 1'b0);
		drive_item(CH_CLOSE, 1'b0);
		// open paren left at the end is flushed like an operator
		drive_item(CH_OPEN, 1'b0);
		drive_item(CH_MINUS, 1'b1);
		// overflow: a full stack of open parens drops the next push
		repeat (STACK_DEPTH + 1) drive_item(CH_OPEN, 1'b0);
		drive_item(CH_MINUS, 1'b0);
		drive_item(CH_POW, 1'b1);

		run_random(PHASE_ITEMS);
		// hold the sender until everything expected so far has come out
		drain_outputs();

		// heavy sender idling, light receiver stalling
		send_idle_pct = 65;
		recv_idle_pct = 21;
		run_random(PHASE_ITEMS);
		drain_outputs();

		// back to back on both sides
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(PHASE_ITEMS);

		drain_outputs();
		fail_total = sb.close_out();
		if (fail_total == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/itp_pkg.sv
hw/rtl/itp_seq.sv
hw/rtl/itp_dp.sv
hw/rtl/infix_to_postfix_converter.sv
verif/tb.sv
